// ===== design/rip_pkg.sv =====
// Shared types and constants for the water ripple height field block.
package rip_pkg;

    typedef enum logic [1:0] {
        FUNC_UPDATE = 2'd0,
        FUNC_DROP   = 2'd1,
        FUNC_FLIP   = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    localparam int FUNC_W   = 2;
    localparam int DEPTH_W  = 16;
    localparam int HEIGHT_W = 32;
    localparam int PIXEL_W  = 24;
    localparam int DAMP_W   = 4;
    localparam logic [DAMP_W-1:0] DAMP_RESET = 4'd5;

    // Read slots of one grid access: the cell and its four linear neighbors.
    localparam int RD_NUM    = 5;
    localparam int RD_CENTER = 0;
    localparam int RD_UP     = 1;
    localparam int RD_DOWN   = 2;
    localparam int RD_LEFT   = 3;
    localparam int RD_RIGHT  = 4;

    // Compute stages after the memory read.
    localparam int STAGES = 4;

    typedef struct packed {
        logic               res;       // item returns a result
        logic               wr;        // item writes the back grid
        logic               drop;      // drop item
        logic               interior;  // update with a neighbor sum
        logic               front;     // grid that is front for this item
        logic [DEPTH_W-1:0] depth;
    } t_ctl;

endpackage

// ===== design/rip_bank.sv =====
// One memory bank: one write port, two registered read ports.
module rip_bank #(
    parameter int AW = 11,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== design/rip_grid.sv =====
// One height grid, split into eight banks by row mod 4 and column parity.
module rip_grid #(
    parameter int XW = 7,
    parameter int YW = 7
) (
    input  logic                                             i_clk,
    input  logic                                             i_re,
    input  logic [rip_pkg::RD_NUM-1:0][YW-1:0]               i_rd_y,
    input  logic [rip_pkg::RD_NUM-1:0][XW-1:0]               i_rd_x,
    input  logic [rip_pkg::RD_NUM-1:0]                       i_rd_pb,
    output logic [rip_pkg::RD_NUM-1:0][rip_pkg::HEIGHT_W-1:0] o_rd_data,
    input  logic                                             i_clr,
    input  logic [((YW > 2) ? YW-2 : 1)+XW-2:0]              i_clr_addr,
    input  logic                                             i_we,
    input  logic [YW-1:0]                                    i_wy,
    input  logic [XW-1:0]                                    i_wx,
    input  logic [rip_pkg::HEIGHT_W-1:0]                     i_wdata
);

    localparam int YPW   = (YW > 2) ? YW-2 : 1;
    localparam int XPW   = XW-1;
    localparam int AW    = YPW+XPW;
    localparam int BANKS = 8;
    localparam int BW    = 3;

    function automatic logic [BW-1:0] bank_of(input logic [YW-1:0] y, input logic [XW-1:0] x);
        return {y[1:0], x[0]};
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [YW-1:0] y, input logic [XW-1:0] x);
        return {YPW'(y >> 2), x[XW-1:1]};
    endfunction

    logic [rip_pkg::RD_NUM-1:0][BW-1:0]               rd_bid;
    logic [rip_pkg::RD_NUM-1:0][AW-1:0]               rd_addr;
    logic [BANKS-1:0][AW-1:0]                         a_addr;
    logic [BANKS-1:0][AW-1:0]                         b_addr;
    logic [BANKS-1:0][rip_pkg::HEIGHT_W-1:0]          a_data;
    logic [BANKS-1:0][rip_pkg::HEIGHT_W-1:0]          b_data;
    logic [BANKS-1:0]                                 bank_we;
    logic [AW-1:0]                                    waddr;
    logic [rip_pkg::HEIGHT_W-1:0]                     wdata;
    logic [rip_pkg::RD_NUM-1:0][BW-1:0]               r_bid;
    logic [rip_pkg::RD_NUM-1:0]                       r_pb;

    // Rows y-1, y, y+1 fall in distinct banks; left and right may collide.
    always_comb begin
        for (int r = 0; r < rip_pkg::RD_NUM; r++) begin
            rd_bid[r]  = bank_of(i_rd_y[r], i_rd_x[r]);
            rd_addr[r] = addr_of(i_rd_y[r], i_rd_x[r]);
        end
        for (int k = 0; k < BANKS; k++) begin
            a_addr[k] = '0;
            b_addr[k] = '0;
            for (int r = 0; r < rip_pkg::RD_NUM; r++) begin
                if (rd_bid[r] == BW'(k)) begin
                    if (i_rd_pb[r]) begin
                        b_addr[k] = rd_addr[r];
                    end else begin
                        a_addr[k] = rd_addr[r];
                    end
                end
            end
        end
    end

    always_comb begin
        waddr = i_clr ? i_clr_addr : addr_of(i_wy, i_wx);
        wdata = i_clr ? '0 : i_wdata;
        for (int k = 0; k < BANKS; k++) begin
            bank_we[k] = i_clr || (i_we && (bank_of(i_wy, i_wx) == BW'(k)));
        end
    end

    for (genvar g = 0; g < BANKS; g++) begin : g_bank
        rip_bank #(
            .AW (AW),
            .DW (rip_pkg::HEIGHT_W)
        ) u_bank (
            .i_clk     (i_clk),
            .i_we      (bank_we[g]),
            .i_waddr   (waddr),
            .i_wdata   (wdata),
            .i_re      (i_re),
            .i_raddr_a (a_addr[g]),
            .i_raddr_b (b_addr[g]),
            .o_rdata_a (a_data[g]),
            .o_rdata_b (b_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_bid <= rd_bid;
            r_pb  <= i_rd_pb;
        end
    end

    always_comb begin
        for (int r = 0; r < rip_pkg::RD_NUM; r++) begin
            o_rd_data[r] = r_pb[r] ? b_data[r_bid[r]] : a_data[r_bid[r]];
        end
    end

endmodule

// ===== design/rip_calc.sv =====
// Height update pipeline: neighbor sum, difference, damping, write back.
module rip_calc #(
    parameter int XW = 7,
    parameter int YW = 7
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_acc,
    input  logic                                              i_stall,
    input  rip_pkg::t_ctl                                     i_ctl,
    input  logic [YW-1:0]                                     i_y,
    input  logic [XW-1:0]                                     i_x,
    input  logic [rip_pkg::DAMP_W-1:0]                        i_damp,
    input  logic [rip_pkg::RD_NUM-1:0][rip_pkg::HEIGHT_W-1:0] i_rd_a,
    input  logic [rip_pkg::RD_NUM-1:0][rip_pkg::HEIGHT_W-1:0] i_rd_b,
    output logic                                              o_we,
    output logic                                              o_wgrid,
    output logic [YW-1:0]                                     o_wy,
    output logic [XW-1:0]                                     o_wx,
    output logic [rip_pkg::HEIGHT_W-1:0]                      o_wdata,
    output logic                                              o_res,
    output logic [rip_pkg::PIXEL_W-1:0]                       o_pixel,
    output logic [rip_pkg::STAGES-1:0]                        o_pend_vld,
    output logic [rip_pkg::STAGES-1:0]                        o_pend_grid,
    output logic [rip_pkg::STAGES-1:0][YW-1:0]                o_pend_y,
    output logic [rip_pkg::STAGES-1:0][XW-1:0]                o_pend_x
);

    localparam int HW   = rip_pkg::HEIGHT_W;
    localparam int LAST = rip_pkg::STAGES-1;
    localparam logic [HW-1:0] GREY_MAX = HW'(255);
    localparam logic [rip_pkg::PIXEL_W-1:0] PIXEL_WHITE = 24'hffffff;

    logic [rip_pkg::STAGES-1:0]          r_vld;
    rip_pkg::t_ctl                       r_ctl [rip_pkg::STAGES];
    logic [rip_pkg::STAGES-1:0][YW-1:0]  r_y;
    logic [rip_pkg::STAGES-1:0][XW-1:0]  r_x;

    logic [HW-1:0] r_p, r_q, r_b2, r_sum, r_b3, r_d, r_b4;
    logic [rip_pkg::PIXEL_W-1:0] r_pix2, r_pix3, r_pix4;

    logic [rip_pkg::RD_NUM-1:0][HW-1:0] front;
    logic [HW-1:0] back;
    logic [HW-1:0] fc;
    logic [rip_pkg::PIXEL_W-1:0] pix;
    logic [HW-1:0] damp_part;
    logic [HW-1:0] new_h;

    // First stage: pick front/back grid, pair sums, drop add, grey pixel.
    always_comb begin
        front = r_ctl[0].front ? i_rd_b : i_rd_a;
        back  = r_ctl[0].front ? i_rd_a[rip_pkg::RD_CENTER] : i_rd_b[rip_pkg::RD_CENTER];
        fc    = front[rip_pkg::RD_CENTER];
        if (fc[HW-1]) begin
            pix = '0;
        end else if (fc > GREY_MAX) begin
            pix = PIXEL_WHITE;
        end else begin
            pix = {3{fc[7:0]}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (!i_stall) begin
            r_vld <= {r_vld[LAST-1:0], i_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            r_ctl[0] <= i_ctl;
            r_y[0]   <= i_y;
            r_x[0]   <= i_x;
            for (int k = 1; k < rip_pkg::STAGES; k++) begin
                r_ctl[k] <= r_ctl[k-1];
                r_y[k]   <= r_y[k-1];
                r_x[k]   <= r_x[k-1];
            end
            r_p    <= front[rip_pkg::RD_UP] + front[rip_pkg::RD_DOWN];
            r_q    <= front[rip_pkg::RD_LEFT] + front[rip_pkg::RD_RIGHT];
            r_b2   <= r_ctl[0].drop ? back + HW'(r_ctl[0].depth) : back;
            r_pix2 <= pix;
            r_sum  <= r_p + r_q;
            r_b3   <= r_b2;
            r_pix3 <= r_pix2;
            r_d    <= {r_sum[HW-1], r_sum[HW-1:1]} - r_b3;
            r_b4   <= r_b3;
            r_pix4 <= r_pix3;
        end
    end

    // Last stage: damping, then write back and hand over the result.
    always_comb begin
        damp_part = $unsigned($signed(r_d) >>> i_damp);
        new_h     = r_d - damp_part;
        o_wdata   = r_ctl[LAST].interior ? new_h : r_b4;
        o_pixel   = r_pix4;
        o_res     = r_vld[LAST] && r_ctl[LAST].res;
        o_we      = r_vld[LAST] && r_ctl[LAST].wr && !i_stall;
        o_wgrid   = !r_ctl[LAST].front;
        o_wy      = r_y[LAST];
        o_wx      = r_x[LAST];
        for (int k = 0; k < rip_pkg::STAGES; k++) begin
            o_pend_vld[k]  = r_vld[k] && r_ctl[k].wr;
            o_pend_grid[k] = !r_ctl[k].front;
        end
        o_pend_y = r_y;
        o_pend_x = r_x;
    end

`ifndef ASSERT_OFF
    for (genvar g = 0; g < LAST; g++) begin : g_chk
        a_unique_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            !(o_pend_vld[LAST] && o_pend_vld[g] && (o_pend_grid[LAST] == o_pend_grid[g])
              && (o_pend_y[LAST] == o_pend_y[g]) && (o_pend_x[LAST] == o_pend_x[g])))
            else $error("two in-flight writes to the same cell");
    end
`endif

endmodule

// ===== design/water_ripple_height_field_step.sv =====
// Top level of the water ripple height field block.
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one item per cycle: func 0
//   updates a cell, 1 adds a drop to the back grid, 2 swaps front and back.
//   Output channel (o_out_valid / i_out_ready) returns one item per update of
//   a cell inside the grid: the new back height and a grey pixel of the front.
//   Config channel (i_cfg_valid / o_cfg_ready) writes damping_shift; always ready.
// Path: an accepted item passes the memory read register, then the pair-sum,
//   neighbor-sum and difference registers, then damping, write back and the output register.
// Throughput: 1 item per cycle outside the reset sweep and stalls. An item that
//   touches a cell with a write still in the 4-stage pipeline waits until that
//   write lands; raster-order streams never hit this.
// Reset: both grids are swept to zero, all 8 banks of both grids at once, one
//   bank row per cycle, through every bank address. No item is taken during
//   the sweep; config writes still are.
// Stall: when the output item is not taken and another result reaches the last
//   stage, the whole pipeline freezes; otherwise input keeps flowing.
module water_ripple_height_field_step #(
    parameter int GRID_W = 128,
    parameter int GRID_H = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rip_pkg::FUNC_W-1:0]          i_func,
    input  logic [$clog2(GRID_W)-1:0]           i_cell_x,
    input  logic [$clog2(GRID_H)-1:0]           i_cell_y,
    input  logic [rip_pkg::DEPTH_W-1:0]         i_drop_depth,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rip_pkg::HEIGHT_W-1:0] o_new_height,
    output logic [rip_pkg::PIXEL_W-1:0]         o_shown_pixel,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rip_pkg::DAMP_W-1:0]          i_cfg_damping_shift
);

    localparam int XW  = $clog2(GRID_W);
    localparam int YW  = $clog2(GRID_H);
    localparam int YPW = (YW > 2) ? YW-2 : 1;
    localparam int XPW = XW-1;
    localparam int AW  = YPW+XPW;
    localparam int NS  = rip_pkg::STAGES;
    localparam int HW  = rip_pkg::HEIGHT_W;

    // Control state
    logic                        r_front;      // 0: grid a is front
    logic [rip_pkg::DAMP_W-1:0]  r_damp;
    logic                        r_clr_busy;
    logic [AW-1:0]               r_clr_addr;
    logic                        r_out_valid;
    logic [HW-1:0]               r_out_height;
    logic [rip_pkg::PIXEL_W-1:0] r_out_pixel;

    // Decode of the incoming item
    rip_pkg::t_func func;
    logic           is_update, is_drop, is_flip;
    logic           in_range, interior;
    rip_pkg::t_ctl  ctl;
    logic           in_accept;
    logic           hazard;
    logic           stall;

    // Cell and its four linear-index neighbors; pb picks bank read port B
    logic [rip_pkg::RD_NUM-1:0][YW-1:0] ny;
    logic [rip_pkg::RD_NUM-1:0][XW-1:0] nx;
    logic [rip_pkg::RD_NUM-1:0]         npb;

    // Pipeline interface
    logic                           c_we, c_wgrid, c_res;
    logic [YW-1:0]                  c_wy;
    logic [XW-1:0]                  c_wx;
    logic [HW-1:0]                  c_wdata;
    logic [rip_pkg::PIXEL_W-1:0]    c_pixel;
    logic [NS-1:0]                  pend_vld, pend_grid;
    logic [NS-1:0][YW-1:0]          pend_y;
    logic [NS-1:0][XW-1:0]          pend_x;
    logic [rip_pkg::RD_NUM-1:0][HW-1:0] rd_a, rd_b;

    always_comb begin
        func      = rip_pkg::t_func'(i_func);
        is_update = 1'b0;
        is_drop   = 1'b0;
        is_flip   = 1'b0;
        unique case (func)
            rip_pkg::FUNC_UPDATE: is_update = 1'b1;
            rip_pkg::FUNC_DROP:   is_drop   = 1'b1;
            rip_pkg::FUNC_FLIP:   is_flip   = 1'b1;
            rip_pkg::FUNC_NOP:    is_flip   = 1'b0;
        endcase
        in_range = ((XW+1)'(i_cell_x) < (XW+1)'(GRID_W))
                && ((YW+1)'(i_cell_y) < (YW+1)'(GRID_H));
        // top and bottom rows keep their back height
        interior = (i_cell_y != '0)
                && (((YW+1)'(i_cell_y) + (YW+1)'(1)) < (YW+1)'(GRID_H));

        ctl.res      = is_update && in_range;
        ctl.wr       = in_range && (is_drop || (is_update && interior));
        ctl.drop     = is_drop;
        ctl.interior = is_update && interior;
        ctl.front    = r_front;
        ctl.depth    = i_drop_depth;
    end

    // Edge columns wrap into the adjacent row, as linear indexing does.
    always_comb begin
        ny[rip_pkg::RD_CENTER]  = i_cell_y;
        nx[rip_pkg::RD_CENTER]  = i_cell_x;
        npb[rip_pkg::RD_CENTER] = 1'b0;
        ny[rip_pkg::RD_UP]      = i_cell_y - YW'(1);
        nx[rip_pkg::RD_UP]      = i_cell_x;
        npb[rip_pkg::RD_UP]     = 1'b0;
        ny[rip_pkg::RD_DOWN]    = i_cell_y + YW'(1);
        nx[rip_pkg::RD_DOWN]    = i_cell_x;
        npb[rip_pkg::RD_DOWN]   = 1'b0;
        if (i_cell_x == '0) begin
            ny[rip_pkg::RD_LEFT]  = i_cell_y - YW'(1);
            nx[rip_pkg::RD_LEFT]  = XW'(GRID_W-1);
            npb[rip_pkg::RD_LEFT] = 1'b1;
        end else begin
            ny[rip_pkg::RD_LEFT]  = i_cell_y;
            nx[rip_pkg::RD_LEFT]  = i_cell_x - XW'(1);
            npb[rip_pkg::RD_LEFT] = 1'b0;
        end
        if (i_cell_x == XW'(GRID_W-1)) begin
            ny[rip_pkg::RD_RIGHT] = i_cell_y + YW'(1);
            nx[rip_pkg::RD_RIGHT] = '0;
        end else begin
            ny[rip_pkg::RD_RIGHT] = i_cell_y;
            nx[rip_pkg::RD_RIGHT] = i_cell_x + XW'(1);
        end
        npb[rip_pkg::RD_RIGHT] = 1'b1;
    end

    // Interlock: hold an item whose reads hit a write still in the pipeline.
    always_comb begin
        logic m_c, m_n;
        hazard = 1'b0;
        for (int k = 0; k < NS; k++) begin
            m_c = (pend_y[k] == i_cell_y) && (pend_x[k] == i_cell_x);
            m_n = 1'b0;
            for (int r = 1; r < rip_pkg::RD_NUM; r++) begin
                m_n = m_n || ((pend_y[k] == ny[r]) && (pend_x[k] == nx[r]));
            end
            hazard = hazard || (pend_vld[k]
                     && (m_c || ((pend_grid[k] == r_front) && is_update && m_n)));
        end
        hazard = hazard && in_range && (is_update || is_drop);
    end

    assign stall       = c_res && r_out_valid && !i_out_ready;
    assign o_in_ready  = !r_clr_busy && !stall && !hazard;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= 1'b0;
            r_damp     <= rip_pkg::DAMP_RESET;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (in_accept && is_flip) begin
                r_front <= !r_front;
            end
            if (i_cfg_valid) begin
                r_damp <= i_cfg_damping_shift;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (&r_clr_addr) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // Output register parts the pipeline from the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_res && !stall) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_res && !stall) begin
            r_out_height <= c_wdata;
            r_out_pixel  <= c_pixel;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_new_height  = $signed(r_out_height);
    assign o_shown_pixel = r_out_pixel;

    rip_grid #(
        .XW (XW),
        .YW (YW)
    ) u_grid_a (
        .i_clk      (i_clk),
        .i_re       (in_accept),
        .i_rd_y     (ny),
        .i_rd_x     (nx),
        .i_rd_pb    (npb),
        .o_rd_data  (rd_a),
        .i_clr      (r_clr_busy),
        .i_clr_addr (r_clr_addr),
        .i_we       (c_we && !c_wgrid),
        .i_wy       (c_wy),
        .i_wx       (c_wx),
        .i_wdata    (c_wdata)
    );

    rip_grid #(
        .XW (XW),
        .YW (YW)
    ) u_grid_b (
        .i_clk      (i_clk),
        .i_re       (in_accept),
        .i_rd_y     (ny),
        .i_rd_x     (nx),
        .i_rd_pb    (npb),
        .o_rd_data  (rd_b),
        .i_clr      (r_clr_busy),
        .i_clr_addr (r_clr_addr),
        .i_we       (c_we && c_wgrid),
        .i_wy       (c_wy),
        .i_wx       (c_wx),
        .i_wdata    (c_wdata)
    );

    rip_calc #(
        .XW (XW),
        .YW (YW)
    ) u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (in_accept && (ctl.res || ctl.wr)),
        .i_stall     (stall),
        .i_ctl       (ctl),
        .i_y         (i_cell_y),
        .i_x         (i_cell_x),
        .i_damp      (r_damp),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .o_we        (c_we),
        .o_wgrid     (c_wgrid),
        .o_wy        (c_wy),
        .o_wx        (c_wx),
        .o_wdata     (c_wdata),
        .o_res       (c_res),
        .o_pixel     (c_pixel),
        .o_pend_vld  (pend_vld),
        .o_pend_grid (pend_grid),
        .o_pend_y    (pend_y),
        .o_pend_x    (pend_x)
    );

`ifndef ASSERT_OFF
    a_clr_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !c_we)
        else $error("grid write during clearing sweep");

    a_clr_full_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> $past(&r_clr_addr))
        else $error("clearing sweep ended early");

    a_flip_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && is_flip) |=> (r_front != $past(r_front)))
        else $error("flip item did not swap grids");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> (c_res && $stable(c_wy) && $stable(c_wx)))
        else $error("last stage moved while output blocked");
`endif

endmodule

// ===== sim/ripple_height_checker.sv =====
// Checker for the water ripple block: shadow height grids, owed results and field compares.
module ripple_height_checker #(
    parameter int GRID_W = 128,
    parameter int GRID_H = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [rip_pkg::FUNC_W-1:0]          i_func,
    input  logic [$clog2(GRID_W)-1:0]           i_cell_x,
    input  logic [$clog2(GRID_H)-1:0]           i_cell_y,
    input  logic [rip_pkg::DEPTH_W-1:0]         i_drop_depth,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [rip_pkg::HEIGHT_W-1:0] i_new_height,
    input  logic [rip_pkg::PIXEL_W-1:0]         i_shown_pixel,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [rip_pkg::DAMP_W-1:0]          i_cfg_damping_shift,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);

    localparam int GRID_CELLS = GRID_W * GRID_H;

    typedef struct packed {
        logic signed [rip_pkg::HEIGHT_W-1:0] height;
        logic [rip_pkg::PIXEL_W-1:0]         pixel;
    } t_ripple_result;

    // heights[front_sel] is the front grid, the other one the back grid
    logic [rip_pkg::HEIGHT_W-1:0] heights [2][GRID_CELLS];
    bit                           front_sel;
    logic [rip_pkg::DAMP_W-1:0]   damping;
    t_ripple_result               owed_results [$];
    int                           mismatches = 0;
    int                           checked = 0;

    function automatic logic [rip_pkg::PIXEL_W-1:0] grey_pixel(
        input logic [rip_pkg::HEIGHT_W-1:0] h);
        if (h[rip_pkg::HEIGHT_W-1])
            return '0;
        if (h > 255)
            return 24'hffffff;
        return h[7:0] * 24'h010101;
    endfunction

    task automatic ripple_step(input rip_pkg::t_func f, input int cx, input int cy,
                               input logic [rip_pkg::DEPTH_W-1:0] dep);
        int                                  idx;
        bit                                  fs;
        logic [rip_pkg::HEIGHT_W-1:0]        nsum;
        logic signed [rip_pkg::HEIGHT_W-1:0] half;
        logic signed [rip_pkg::HEIGHT_W-1:0] diff;
        logic signed [rip_pkg::HEIGHT_W-1:0] damped;
        t_ripple_result                      res;
        fs = front_sel;
        if (f == rip_pkg::FUNC_FLIP) begin
            front_sel = !front_sel;
            return;
        end
        if (f == rip_pkg::FUNC_NOP)
            return;
        if (cx >= GRID_W || cy >= GRID_H)
            return;
        idx = cy * GRID_W + cx;
        if (f == rip_pkg::FUNC_DROP) begin
            heights[!fs][idx] = heights[!fs][idx] + {16'd0, dep};
            return;
        end
        // top and bottom rows keep their back height
        if (cy >= 1 && cy + 1 < GRID_H) begin
            nsum = heights[fs][idx-1] + heights[fs][idx+1]
                 + heights[fs][idx-GRID_W] + heights[fs][idx+GRID_W];
            half   = $signed(nsum) >>> 1;
            diff   = half - $signed(heights[!fs][idx]);
            damped = diff >>> damping;
            heights[!fs][idx] = diff - damped;
        end
        res.height = heights[!fs][idx];
        res.pixel  = grey_pixel(heights[fs][idx]);
        owed_results.push_back(res);
    endtask

    always @(posedge i_clk) begin : watch
        t_ripple_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < GRID_CELLS; k++) begin
                heights[0][k] = '0;
                heights[1][k] = '0;
            end
            front_sel = 1'b0;
            damping   = rip_pkg::DAMP_RESET;
            owed_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                damping = i_cfg_damping_shift;
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual height %0d pixel %h",
                             $time, i_new_height, i_shown_pixel);
                end else begin
                    want = owed_results.pop_front();
                    checked++;
                    if (want.height !== i_new_height) begin
                        mismatches++;
                        $display("%0t: new_height expected %0d actual %0d",
                                 $time, want.height, i_new_height);
                    end
                    if (want.pixel !== i_shown_pixel) begin
                        mismatches++;
                        $display("%0t: shown_pixel expected %h actual %h",
                                 $time, want.pixel, i_shown_pixel);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                ripple_step(rip_pkg::t_func'(i_func), int'(i_cell_x), int'(i_cell_y),
                            i_drop_depth);
        end
        o_fail_count <= mismatches;
        o_pending    <= owed_results.size();
        o_checked    <= checked;
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the water ripple height field block: stimulus, flow control and verdict.
module tb;

    localparam int GRID_W      = 128;
    localparam int GRID_H      = 128;
    localparam int XW          = $clog2(GRID_W);
    localparam int YW          = $clog2(GRID_H);
    localparam int PHASE_ITEMS = 140;     // random items per damping setting
    localparam int PHASES      = 5;
    localparam int TAIL_CYCLES = 8;       // pipeline is 4 deep; drops and flips leave no result
    localparam int CYCLE_LIMIT = 400000;  // covers the clear sweep many times over

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    // input item channel
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    rip_pkg::t_func                  in_func = rip_pkg::FUNC_NOP;
    logic [XW-1:0]                   in_x = '0;
    logic [YW-1:0]                   in_y = '0;
    logic [rip_pkg::DEPTH_W-1:0]     in_depth = '0;

    // result channel
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [rip_pkg::HEIGHT_W-1:0] new_height;
    logic [rip_pkg::PIXEL_W-1:0]         shown_pixel;

    // damping register write channel
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [rip_pkg::DAMP_W-1:0]  cfg_shift = '0;

    // when set, neither side inserts bubbles
    bit                     quiet = 1'b0;

    int                     fail_count;
    int                     pending;
    int                     checked;
    int                     cycle_count = 0;
    int                     n_update = 0;
    int                     n_drop = 0;
    int                     n_flip = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    water_ripple_height_field_step #(
        .GRID_W(GRID_W),
        .GRID_H(GRID_H)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_func             (in_func),
        .i_cell_x           (in_x),
        .i_cell_y           (in_y),
        .i_drop_depth       (in_depth),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_new_height       (new_height),
        .o_shown_pixel      (shown_pixel),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_damping_shift(cfg_shift)
    );

    ripple_height_checker #(
        .GRID_W(GRID_W),
        .GRID_H(GRID_H)
    ) u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_func             (in_func),
        .i_cell_x           (in_x),
        .i_cell_y           (in_y),
        .i_drop_depth       (in_depth),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_new_height       (new_height),
        .i_shown_pixel      (shown_pixel),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_damping_shift(cfg_shift),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    // Receiver backpressure: drop ready about 18% of cycles unless in a quiet stretch.
    always @(posedge clk) begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 18);
    end

    // Watchdog; a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one item and hold it until the block takes it. Valid is left high on
    // return so back-to-back items never lower and raise it in one step.
    task automatic send_cell_op(input rip_pkg::t_func f, input int cx, input int cy,
                                input int dep);
        while (!quiet && $urandom_range(0, 99) < 18) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= f;
        in_x     <= XW'(cx);
        in_y     <= YW'(cy);
        in_depth <= dep[rip_pkg::DEPTH_W-1:0];
        do @(posedge clk); while (!in_ready);
        case (f)
            rip_pkg::FUNC_UPDATE: n_update++;
            rip_pkg::FUNC_DROP:   n_drop++;
            rip_pkg::FUNC_FLIP:   n_flip++;
            default: ;
        endcase
    endtask

    // Random item. Most land in a small patch that straddles the left/right
    // wrap near the top row, so drops, flips and updates feed one another;
    // the rest spread over the whole grid, bottom rows included.
    task automatic send_random_op(output bit counted);
        int             roll;
        int             cx;
        int             cy;
        int             dep;
        rip_pkg::t_func f;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            f = rip_pkg::FUNC_UPDATE;
        else if (roll < 84)
            f = rip_pkg::FUNC_DROP;
        else if (roll < 96)
            f = rip_pkg::FUNC_FLIP;
        else
            f = rip_pkg::FUNC_NOP;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            cx = (124 + $urandom_range(0, 7)) % GRID_W;
            cy = $urandom_range(0, 6);
        end else if (roll < 75) begin
            cx = (124 + $urandom_range(0, 7)) % GRID_W;
            cy = $urandom_range(GRID_H - 7, GRID_H - 1);
        end else begin
            cx = $urandom_range(0, GRID_W - 1);
            cy = $urandom_range(0, GRID_H - 1);
        end
        if ($urandom_range(0, 99) < 70)
            dep = $urandom_range(0, 300);
        else
            dep = $urandom_range(0, 65535);
        send_cell_op(f, cx, cy, dep);
        counted = (f != rip_pkg::FUNC_NOP);
    endtask

    // Park the input, let every owed result drain, then give items that leave
    // no result time to clear the pipeline.
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_damping(input logic [rip_pkg::DAMP_W-1:0] shift);
        cfg_valid <= 1'b1;
        cfg_shift <= shift;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [rip_pkg::DAMP_W-1:0] settings [PHASES];
        int                         done;
        int                         rnd_shift;
        bit                         counted;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, damping at its reset value.
        send_cell_op(rip_pkg::FUNC_UPDATE, 64, 64, 0);            // all-zero grid
        send_cell_op(rip_pkg::FUNC_DROP, 64, 64, 100);
        send_cell_op(rip_pkg::FUNC_DROP, 63, 64, 65535);          // largest depth
        send_cell_op(rip_pkg::FUNC_DROP, 0, 1, 300);
        send_cell_op(rip_pkg::FUNC_DROP, GRID_W - 1, 0, 7);       // top row, far corner
        send_cell_op(rip_pkg::FUNC_DROP, 0, 0, 0);                // zero depth
        send_cell_op(rip_pkg::FUNC_FLIP, 0, 0, 0);                // drops now sit in the front grid
        send_cell_op(rip_pkg::FUNC_UPDATE, 64, 64, 0);            // grey pixel in range
        send_cell_op(rip_pkg::FUNC_UPDATE, 63, 64, 0);            // front above 255
        send_cell_op(rip_pkg::FUNC_UPDATE, 0, 1, 0);              // left neighbor wraps to previous row
        send_cell_op(rip_pkg::FUNC_UPDATE, GRID_W - 1, 1, 0);     // right neighbor wraps to next row
        send_cell_op(rip_pkg::FUNC_UPDATE, 5, 0, 0);              // top row, back left alone
        send_cell_op(rip_pkg::FUNC_UPDATE, GRID_W - 1, 0, 0);
        send_cell_op(rip_pkg::FUNC_UPDATE, 9, GRID_H - 1, 0);     // bottom row
        send_cell_op(rip_pkg::FUNC_NOP, 64, 64, 65535);           // unused code, no result
        send_cell_op(rip_pkg::FUNC_DROP, GRID_W - 1, GRID_H - 1, 32768);
        send_cell_op(rip_pkg::FUNC_FLIP, GRID_W - 1, GRID_H - 1, 65535);
        send_cell_op(rip_pkg::FUNC_UPDATE, 64, 64, 0);            // back exceeds neighbor average
        send_cell_op(rip_pkg::FUNC_FLIP, 0, 0, 0);
        send_cell_op(rip_pkg::FUNC_UPDATE, 64, 64, 0);            // negative front clamps to zero
        send_cell_op(rip_pkg::FUNC_UPDATE, GRID_W - 1, GRID_H - 1, 0);
        send_cell_op(rip_pkg::FUNC_UPDATE, 0, 0, 0);

        // Random part across several damping settings, both extremes included.
        rnd_shift   = $urandom_range(1, 14);
        settings[0] = 4'd0;
        settings[1] = 4'd15;
        settings[2] = rnd_shift[rip_pkg::DAMP_W-1:0];
        settings[3] = 4'd1;
        settings[4] = rip_pkg::DAMP_RESET;
        for (int p = 0; p < PHASES; p++) begin
            drain_block();
            write_damping(settings[p]);
            quiet <= (p == 3);   // one long stretch with no bubbles either side
            done = 0;
            while (done < PHASE_ITEMS) begin
                send_random_op(counted);
                if (counted)
                    done++;
            end
        end
        drain_block();

        $display("Ran %0d updates, %0d drops and %0d flips over %0d damping settings",
                 n_update, n_drop, n_flip, PHASES + 1);
        $display("%0d results compared field by field, %0d mismatches", checked, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
